// ===== hw/rtl/phpwm_pkg.sv =====
// Package for the proximity haptic PWM block: item kinds, register
// indexes and configuration reset values.
// Depends on nothing; imported by proximity_haptic_pwm.
package phpwm_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE_RANGE = 2'd0,
    FUNC_CLOSE_CHECK = 2'd1,
    FUNC_PWM_TICK    = 2'd2,
    FUNC_PULSE_TICK  = 2'd3
  } func_t;

  localparam logic [1:0] REG_NEAR_LIMIT    = 2'd0;
  localparam logic [1:0] REG_MAX_VALUE     = 2'd1;
  localparam logic [1:0] REG_PULSE_PERIOD  = 2'd2;

  localparam logic [15:0] NEAR_LIMIT_RST   = 16'd1000;
  localparam logic [15:0] MAX_VALUE_RST    = 16'd2000;
  localparam logic [7:0]  PULSE_PERIOD_RST = 8'd1;

  localparam int OUT_CELLS = 6;

endpackage

// ===== hw/rtl/proximity_haptic_pwm.sv =====
// Proximity haptic PWM: per-cell range store, near detection, PWM off/on
// counters and pulse gating, with an APB register port.
// Depends on phpwm_pkg.
//
//   channel   | dir | handshake              | payload
//   ----------+-----+------------------------+----------------------------------
//   s_axis    | in  | s_tvalid / s_tready    | tuser: func; tdata: cell, range
//   m_axis    | out | m_tvalid / m_tready    | tdata: motor_enables, near_flags
//   apb       | in  | psel, penable, pready  | paddr, pwdata, prdata
//
// Each accepted item's word is registered onto m_tdata, or into the skid
// register while the output is held; one item per cycle is sustained while m_tready stays high.
// All cells update in parallel in a single pass from the per-cell state.
// A two-entry output stage (output register plus skid) lets one further
// item in while a word waits; s_tready drops only when both are full.
// rst is synchronous and clears all cell state; motors are off after reset.
module proximity_haptic_pwm
  import phpwm_pkg::*;
#(
  parameter int CELLS      = 6,
  parameter int RANGE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [2:0] cell_index, [18:3] range_value, rest zero
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] motor_enables, [11:6] near_flags, rest zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CMP_W = (RANGE_BITS > 16) ? RANGE_BITS : 16;

  logic [15:0] near_limit;
  logic [15:0] max_value;
  logic [7:0]  pulse_period;

  logic [RANGE_BITS-1:0] range_store [CELLS];
  logic [RANGE_BITS-1:0] off_count   [CELLS];
  logic [RANGE_BITS-1:0] on_count    [CELLS];
  logic [7:0]            pulse_count [CELLS];
  logic [CELLS-1:0]      motor_on;
  logic [CELLS-1:0]      near;
  logic [CELLS-1:0]      pulse_phase;

  logic [RANGE_BITS-1:0] range_store_next [CELLS];
  logic [RANGE_BITS-1:0] off_count_next   [CELLS];
  logic [RANGE_BITS-1:0] on_count_next    [CELLS];
  logic [7:0]            pulse_count_next [CELLS];
  logic [CELLS-1:0]      motor_on_next;
  logic [CELLS-1:0]      near_next;
  logic [CELLS-1:0]      pulse_phase_next;

  logic                  accept;
  func_t                 func;
  logic [2:0]            cell_index;
  logic [15:0]           range_value;
  logic [CMP_W-1:0]      range_ext;
  logic [RANGE_BITS-1:0] new_range;
  logic [CMP_W-1:0]      thr_ext;
  logic [CMP_W-1:0]      max_ext;
  logic [15:0]           result;

  logic                  skid_valid;
  logic [15:0]           skid_data;
  logic                  cfg_write;

  // ---------------------------------------------------------------- config

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit   <= NEAR_LIMIT_RST;
      max_value    <= MAX_VALUE_RST;
      pulse_period <= PULSE_PERIOD_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_NEAR_LIMIT:   near_limit   <= pwdata[15:0];
        REG_MAX_VALUE:    max_value    <= pwdata[15:0];
        REG_PULSE_PERIOD: pulse_period <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NEAR_LIMIT:   prdata = {16'd0, near_limit};
      REG_MAX_VALUE:    prdata = {16'd0, max_value};
      REG_PULSE_PERIOD: prdata = {24'd0, pulse_period};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- cells

  assign s_tready    = !skid_valid;
  assign accept      = s_tvalid && s_tready;
  assign func        = func_t'(s_tuser);
  assign cell_index  = s_tdata[2:0];
  assign range_value = s_tdata[18:3];
  assign range_ext   = CMP_W'(range_value);
  assign new_range   = range_ext[RANGE_BITS-1:0];
  assign thr_ext     = CMP_W'(near_limit);
  assign max_ext     = CMP_W'(max_value);

  always_comb begin
    logic [CMP_W-1:0]      v_ext;
    logic [CMP_W-1:0]      diff;
    logic [RANGE_BITS-1:0] dec;
    logic [7:0]            pdec;
    for (int c = 0; c < CELLS; c++) begin
      range_store_next[c] = range_store[c];
      off_count_next[c]   = off_count[c];
      on_count_next[c]    = on_count[c];
      pulse_count_next[c] = pulse_count[c];
      motor_on_next[c]    = motor_on[c];
      near_next[c]        = near[c];
      pulse_phase_next[c] = pulse_phase[c];
      v_ext = CMP_W'(range_store[c]);
      diff  = max_ext - v_ext;
      dec   = '0;
      pdec  = pulse_count[c] - 8'd1;
      case (func)
        FUNC_WRITE_RANGE: begin
          if ({2'b00, cell_index} == 5'(c)) begin
            range_store_next[c] = new_range;
          end
        end
        FUNC_CLOSE_CHECK: begin
          if (v_ext < thr_ext) begin
            // Only a cell that has just become near is re-armed.
            if (!near[c]) begin
              near_next[c]        = 1'b1;
              pulse_phase_next[c] = 1'b1;
              pulse_count_next[c] = pulse_period;
            end
          end else begin
            near_next[c] = 1'b0;
          end
        end
        FUNC_PWM_TICK: begin
          if (!motor_on[c]) begin
            dec = (off_count[c] != '0) ? off_count[c] - RANGE_BITS'(1) : '0;
            if (dec == '0) begin
              off_count_next[c] = range_store[c];
              if ((!near[c] || pulse_phase[c]) && (v_ext < max_ext)) begin
                motor_on_next[c] = 1'b1;
              end
            end else begin
              off_count_next[c] = dec;
            end
          end else begin
            dec = (on_count[c] != '0) ? on_count[c] - RANGE_BITS'(1) : '0;
            if (dec == '0) begin
              on_count_next[c] = (max_ext > v_ext) ? diff[RANGE_BITS-1:0] : '0;
              motor_on_next[c] = 1'b0;
            end else begin
              on_count_next[c] = dec;
            end
          end
        end
        FUNC_PULSE_TICK: begin
          if (near[c]) begin
            if (pdec == 8'd0) begin
              pulse_phase_next[c] = !pulse_phase[c];
              pulse_count_next[c] = pulse_period;
            end else begin
              pulse_count_next[c] = pdec;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CELLS; c++) begin
        range_store[c] <= '0;
        off_count[c]   <= '0;
        on_count[c]    <= '0;
        pulse_count[c] <= '0;
      end
      motor_on    <= '0;
      near        <= '0;
      pulse_phase <= '0;
    end else if (accept) begin
      for (int c = 0; c < CELLS; c++) begin
        range_store[c] <= range_store_next[c];
        off_count[c]   <= off_count_next[c];
        on_count[c]    <= on_count_next[c];
        pulse_count[c] <= pulse_count_next[c];
      end
      motor_on    <= motor_on_next;
      near        <= near_next;
      pulse_phase <= pulse_phase_next;
    end
  end

  // Only cells 0 to 5 are reported; missing cells read as zero.
  always_comb begin
    result = '0;
    for (int i = 0; i < OUT_CELLS; i++) begin
      if (i < CELLS) begin
        result[i]             = motor_on_next[i];
        result[OUT_CELLS + i] = near_next[i];
      end
    end
  end

  // ---------------------------------------------------------------- output

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
      end else if (accept) begin
        m_tdata <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid word held without an output word");

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted word did not reach the output");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !skid_valid && !accept) |=> !m_tvalid)
    else $error("output word repeated after it was taken");

  a_zero_threshold_clears_near: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_CLOSE_CHECK) && (near_limit == 16'd0))
      |=> (near == '0))
    else $error("cell left near with a zero threshold");
`endif

endmodule
